// ----- src/mpd_pkg.sv -----
// Package for the motion pixel difference and background update block.
// Holds payload types, register codes, reset values and grey coefficients.
// Used by every module in src; depends on nothing.
`default_nettype none
package mpd_pkg;

  localparam logic [7:0]  GREY_KR = 8'd77;
  localparam logic [7:0]  GREY_KG = 8'd151;
  localparam logic [7:0]  GREY_KB = 8'd28;
  localparam logic [8:0]  Q8_ONE  = 9'd256;

  localparam logic [7:0]  THRESHOLD_RESET = 8'd80;
  localparam logic [8:0]  WEIGHT_RESET    = 9'd205;
  localparam logic [15:0] MARKED_RESET    = 16'hFFFF;
  localparam logic [15:0] UNMARKED_RESET  = 16'h0000;

  localparam int CFG_INDEX_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIFF_THRESHOLD    = 8'd0,
    REG_BACKGROUND_WEIGHT = 8'd1,
    REG_MARKED_COLOUR     = 8'd2,
    REG_UNMARKED_COLOUR   = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] bg_pixel;
    logic [15:0] cur_pixel;
  } px_in_t;

  // channel index 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [2:0][15:0] gy_bg;
    logic [2:0][15:0] gy_cur;
    logic [2:0][15:0] bl_old;
    logic [2:0][15:0] bl_cur;
  } prod_t;

  typedef struct packed {
    logic [7:0]      grey_bg;
    logic [7:0]      grey_cur;
    logic [2:0][7:0] new_c;
  } sum_t;

  typedef struct packed {
    logic        motion;
    logic [15:0] mask_pixel;
    logic [15:0] new_bg_pixel;
  } res_t;

  typedef struct packed {
    logic [7:0]  diff_threshold;
    logic [15:0] marked_colour;
    logic [15:0] unmarked_colour;
  } decide_cfg_t;

endpackage
`default_nettype wire

// ----- src/mpd_mult.sv -----
// First pipeline stage: expands both RGB565 pixels to 8-bit channels and
// forms grey and blend products. Depends on mpd_pkg.
`default_nettype none
module mpd_mult (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mpd_pkg::px_in_t in_data,
  input  wire logic [8:0]     weight,
  input  wire logic [8:0]     weight_inv,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mpd_pkg::prod_t      out_data
);

  logic [2:0][7:0] ch_bg;
  logic [2:0][7:0] ch_cur;
  mpd_pkg::prod_t  prod;

  always_comb begin
    ch_bg[0]  = {in_data.bg_pixel[15:11], 3'b000};
    ch_bg[1]  = {in_data.bg_pixel[10:5], 2'b00};
    ch_bg[2]  = {in_data.bg_pixel[4:0], 3'b000};
    ch_cur[0] = {in_data.cur_pixel[15:11], 3'b000};
    ch_cur[1] = {in_data.cur_pixel[10:5], 2'b00};
    ch_cur[2] = {in_data.cur_pixel[4:0], 3'b000};
    prod.gy_bg[0]  = 16'(ch_bg[0]) * 16'(mpd_pkg::GREY_KR);
    prod.gy_bg[1]  = 16'(ch_bg[1]) * 16'(mpd_pkg::GREY_KG);
    prod.gy_bg[2]  = 16'(ch_bg[2]) * 16'(mpd_pkg::GREY_KB);
    prod.gy_cur[0] = 16'(ch_cur[0]) * 16'(mpd_pkg::GREY_KR);
    prod.gy_cur[1] = 16'(ch_cur[1]) * 16'(mpd_pkg::GREY_KG);
    prod.gy_cur[2] = 16'(ch_cur[2]) * 16'(mpd_pkg::GREY_KB);
    for (int i = 0; i < 3; i++) begin
      prod.bl_old[i] = 16'(ch_bg[i]) * 16'(weight);
      prod.bl_cur[i] = 16'(ch_cur[i]) * 16'(weight_inv);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= prod;
    end
  end

endmodule
`default_nettype wire

// ----- src/mpd_sum.sv -----
// Second pipeline stage: adds the products and scales by 1/256 to get
// grey levels and blended channels. Depends on mpd_pkg.
`default_nettype none
module mpd_sum (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mpd_pkg::prod_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mpd_pkg::sum_t       out_data
);

  logic [17:0]       grey_bg_sum;
  logic [17:0]       grey_cur_sum;
  logic [2:0][16:0]  blend_sum;
  mpd_pkg::sum_t     sums;

  always_comb begin
    grey_bg_sum  = 18'(in_data.gy_bg[0]) + 18'(in_data.gy_bg[1]) + 18'(in_data.gy_bg[2]);
    grey_cur_sum = 18'(in_data.gy_cur[0]) + 18'(in_data.gy_cur[1])
                 + 18'(in_data.gy_cur[2]);
    sums.grey_bg  = grey_bg_sum[15:8];
    sums.grey_cur = grey_cur_sum[15:8];
    for (int i = 0; i < 3; i++) begin
      blend_sum[i]  = 17'(in_data.bl_old[i]) + 17'(in_data.bl_cur[i]);
      sums.new_c[i] = blend_sum[i][15:8];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= sums;
    end
  end

endmodule
`default_nettype wire

// ----- src/mpd_decide.sv -----
// Third pipeline stage and output register: grey difference against the
// threshold, mask colour select and RGB565 repack. Depends on mpd_pkg.
`default_nettype none
module mpd_decide (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mpd_pkg::sum_t       in_data,
  input  wire mpd_pkg::decide_cfg_t cfg,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mpd_pkg::res_t            out_data
);

  logic [7:0]    diff;
  mpd_pkg::res_t res;

  always_comb begin
    diff = (in_data.grey_bg > in_data.grey_cur) ? in_data.grey_bg - in_data.grey_cur
                                                : in_data.grey_cur - in_data.grey_bg;
    res.motion       = diff >= cfg.diff_threshold;
    res.mask_pixel   = res.motion ? cfg.marked_colour : cfg.unmarked_colour;
    res.new_bg_pixel = {in_data.new_c[0][7:3], in_data.new_c[1][7:2], in_data.new_c[2][7:3]};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

// ----- src/motion_pixel_diff_and_background_update_top.sv -----
// Top level of the motion pixel difference and background update block.
// Holds the configuration registers and chains mpd_mult, mpd_sum, mpd_decide.
//
// channel  | direction | handshake          | payload
// s_*      | in        | s_tvalid/s_tready  | s_tdata: bg_pixel, cur_pixel
// m_*      | out       | m_tvalid/m_tready  | m_tdata: motion, mask_pixel, new_bg_pixel
// cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel per clock sustained while m_tready stays high; each request passes through
// the product, sum and decide register stages before its result appears.
// Reset is synchronous and clears all stage valid bits and loads register defaults.
// A stalled output holds its request; upstream stages keep filling bubbles.
// cfg_ready is always high; writes take effect on the next cycle.
`default_nettype none
module motion_pixel_diff_and_background_update_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] bg_pixel, [31:16] cur_pixel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [0] motion, [16:1] mask_pixel,
                                      // [32:17] new_bg_pixel, [39:33] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [mpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [7:0]  diff_threshold;
  logic [8:0]  background_weight;
  logic [15:0] marked_colour;
  logic [15:0] unmarked_colour;

  logic [8:0]  weight;
  logic [8:0]  weight_inv;

  mpd_pkg::px_in_t     px_in;
  mpd_pkg::prod_t      prod;
  mpd_pkg::sum_t       sums;
  mpd_pkg::res_t       res;
  mpd_pkg::decide_cfg_t dcfg;

  logic prod_valid, prod_ready;
  logic sum_valid, sum_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold    <= mpd_pkg::THRESHOLD_RESET;
      background_weight <= mpd_pkg::WEIGHT_RESET;
      marked_colour     <= mpd_pkg::MARKED_RESET;
      unmarked_colour   <= mpd_pkg::UNMARKED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mpd_pkg::REG_DIFF_THRESHOLD:    diff_threshold    <= cfg_data[7:0];
        mpd_pkg::REG_BACKGROUND_WEIGHT: background_weight <= cfg_data[8:0];
        mpd_pkg::REG_MARKED_COLOUR:     marked_colour     <= cfg_data;
        mpd_pkg::REG_UNMARKED_COLOUR:   unmarked_colour   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp weight to 1.0
  assign weight     = background_weight[8] ? mpd_pkg::Q8_ONE : background_weight;
  assign weight_inv = mpd_pkg::Q8_ONE - weight;

  assign px_in.bg_pixel  = s_tdata[15:0];
  assign px_in.cur_pixel = s_tdata[31:16];

  assign dcfg.diff_threshold  = diff_threshold;
  assign dcfg.marked_colour   = marked_colour;
  assign dcfg.unmarked_colour = unmarked_colour;

  mpd_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (px_in),
    .weight     (weight),
    .weight_inv (weight_inv),
    .out_valid  (prod_valid),
    .out_ready  (prod_ready),
    .out_data   (prod)
  );

  mpd_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_data  (sums)
  );

  mpd_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_data   (sums),
    .cfg       (dcfg),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {7'b0, res.new_bg_pixel, res.mask_pixel, res.motion};

`ifndef ASSERT_OFF
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output side is taking results");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid && !prod_valid && !sum_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

// ----- dv/motion_pixel_diff_and_background_update_top_test.sv -----
// Self-checking test of motion_pixel_diff_and_background_update_top: random stream
// traffic with idle and stall gaps, register writes between phases, scoreboard compare.
// Depends on mpd_pkg and the top level in src.
module motion_pixel_diff_and_background_update_top_test;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int RANDOM_PHASES   = 9;
  localparam int MAX_GAP         = 14;
  localparam int PIPE_DEPTH      = 6;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int INDEX_MAX       = (1 << mpd_pkg::CFG_INDEX_W) - 1;

  class pixel_scoreboard;
    logic [7:0]     threshold;
    logic [8:0]     weight;
    logic [15:0]    marked;
    logic [15:0]    unmarked;
    mpd_pkg::res_t  pending_results[$];
    int             mismatches;

    function new();
      threshold  = mpd_pkg::THRESHOLD_RESET;
      weight     = mpd_pkg::WEIGHT_RESET;
      marked     = mpd_pkg::MARKED_RESET;
      unmarked   = mpd_pkg::UNMARKED_RESET;
      mismatches = 0;
    endfunction

    function void apply_write(logic [mpd_pkg::CFG_INDEX_W-1:0] index, logic [15:0] data);
      case (index)
        mpd_pkg::REG_DIFF_THRESHOLD: begin
          threshold = data[7:0];
        end
        mpd_pkg::REG_BACKGROUND_WEIGHT: begin
          weight = data[8:0];
        end
        mpd_pkg::REG_MARKED_COLOUR: begin
          marked = data;
        end
        mpd_pkg::REG_UNMARKED_COLOUR: begin
          unmarked = data;
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned grey_level(logic [15:0] p);
      int unsigned r, g, b;
      r = {p[15:11], 3'b000};
      g = {p[10:5], 2'b00};
      b = {p[4:0], 3'b000};
      return (mpd_pkg::GREY_KR * r + mpd_pkg::GREY_KG * g + mpd_pkg::GREY_KB * b) >> 8;
    endfunction

    function logic [7:0] blend_channel(int unsigned old_c, int unsigned cur_c, int unsigned w);
      return 8'((old_c * w + cur_c * (mpd_pkg::Q8_ONE - w)) >> 8);
    endfunction

    function mpd_pkg::res_t predict_pixel(logic [15:0] bg, logic [15:0] cur);
      mpd_pkg::res_t res;
      int unsigned   gb, gc, gap, w;
      logic [7:0]    nr, ng, nb;
      gb = grey_level(bg);
      gc = grey_level(cur);
      gap = (gb > gc) ? gb - gc : gc - gb;
      w = (weight > mpd_pkg::Q8_ONE) ? mpd_pkg::Q8_ONE : weight;
      nr = blend_channel({bg[15:11], 3'b000}, {cur[15:11], 3'b000}, w);
      ng = blend_channel({bg[10:5], 2'b00}, {cur[10:5], 2'b00}, w);
      nb = blend_channel({bg[4:0], 3'b000}, {cur[4:0], 3'b000}, w);
      res.motion       = (gap >= threshold);
      res.mask_pixel   = res.motion ? marked : unmarked;
      res.new_bg_pixel = {nr[7:3], ng[7:2], nb[7:3]};
      return res;
    endfunction

    function void note_request(logic [15:0] bg, logic [15:0] cur);
      pending_results = {pending_results, predict_pixel(bg, cur)};
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [39:0] word);
      mpd_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", word));
        return;
      end
      want = pending_results.pop_front();
      if (word[0] !== want.motion) begin
        report_mismatch($sformatf("motion %b, want %b", word[0], want.motion));
      end
      if (word[16:1] !== want.mask_pixel) begin
        report_mismatch($sformatf("mask_pixel %h, want %h", word[16:1], want.mask_pixel));
      end
      if (word[32:17] !== want.new_bg_pixel) begin
        report_mismatch($sformatf("new_bg_pixel %h, want %h", word[32:17],
                                  want.new_bg_pixel));
      end
      if (word[39:33] !== '0) begin
        report_mismatch($sformatf("padding bits %b not zero", word[39:33]));
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [31:0]                     s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [39:0]                     m_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [mpd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]                     cfg_data;

  pixel_scoreboard sb;
  bit              in_quiet = 1'b0;
  bit              out_quiet = 1'b0;
  int              cycle_count = 0;

  motion_pixel_diff_and_background_update_top DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("motion_pixel_diff_and_background_update_top_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_request(s_tdata[15:0], s_tdata[31:16]);
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
      end
    end
  end

  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task send_pixel(logic [15:0] bg, logic [15:0] cur);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {cur, bg};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task write_reg(logic [mpd_pkg::CFG_INDEX_W-1:0] index, logic [15:0] data);
    cfg_index <= index;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_write(index, data);
  endtask

  task settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  initial begin
    logic [15:0] bg, cur, word;
    int          kind;
    sb = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values; grey difference of 80 and 79 around the threshold
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hF800, 16'h0000);
    send_pixel(16'h07E0, 16'h0000);
    send_pixel(16'h001F, 16'h0000);
    send_pixel(16'h0000, 16'h07E0);
    send_pixel(16'h0440, 16'h0000);
    send_pixel(16'h0422, 16'h0000);
    send_pixel(16'h0000, 16'h0440);
    send_pixel(16'h0000, 16'h0422);
    send_pixel(16'hAAAA, 16'h5555);
    send_pixel(16'h5555, 16'hAAAA);
    settle();

    // zero threshold marks everything; zero weight takes the current pixel
    write_reg(mpd_pkg::REG_DIFF_THRESHOLD, 16'hA500);
    write_reg(mpd_pkg::REG_BACKGROUND_WEIGHT, 16'h0000);
    write_reg(mpd_pkg::REG_MARKED_COLOUR, 16'h1234);
    write_reg(mpd_pkg::REG_UNMARKED_COLOUR, 16'hFEDC);
    cfg_valid <= 1'b0;
    send_pixel(16'h1234, 16'h1234);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'h8421);
    settle();

    write_reg(mpd_pkg::REG_DIFF_THRESHOLD, 16'h00FF);
    write_reg(mpd_pkg::REG_BACKGROUND_WEIGHT, 16'h0100);
    cfg_valid <= 1'b0;
    send_pixel(16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'h07E0, 16'h001F);
    settle();

    // weight above one saturates; unused indexes are dropped
    write_reg(mpd_pkg::REG_DIFF_THRESHOLD, 16'h0010);
    write_reg(mpd_pkg::REG_BACKGROUND_WEIGHT, 16'hFFFF);
    write_reg(mpd_pkg::CFG_INDEX_W'(mpd_pkg::REG_UNMARKED_COLOUR + 1), 16'h0000);
    write_reg(mpd_pkg::CFG_INDEX_W'(INDEX_MAX), 16'h0000);
    cfg_valid <= 1'b0;
    send_pixel(16'hF800, 16'h07E0);
    send_pixel(16'h1234, 16'h5678);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      word = 16'($urandom);
      case ($urandom_range(0, 3))
        0: word[7:0] = 8'h00;
        1: word[7:0] = 8'hFF;
        default: begin
        end
      endcase
      write_reg(mpd_pkg::REG_DIFF_THRESHOLD, word);
      word = 16'($urandom);
      case ($urandom_range(0, 4))
        0: word[8:0] = '0;
        1: word[8:0] = mpd_pkg::Q8_ONE;
        2: word[8:0] = 9'($urandom_range(mpd_pkg::Q8_ONE + 1, 511));
        default: word[8:0] = 9'($urandom_range(0, mpd_pkg::Q8_ONE));
      endcase
      write_reg(mpd_pkg::REG_BACKGROUND_WEIGHT, word);
      write_reg(mpd_pkg::REG_MARKED_COLOUR, 16'($urandom));
      write_reg(mpd_pkg::REG_UNMARKED_COLOUR, 16'($urandom));
      if ($urandom_range(0, 1) == 1) begin
        write_reg(mpd_pkg::CFG_INDEX_W'($urandom_range(mpd_pkg::REG_UNMARKED_COLOUR + 1,
                                                       INDEX_MAX)),
                  16'($urandom));
      end
      cfg_valid <= 1'b0;
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 3);
        bg  = 16'($urandom);
        cur = 16'($urandom);
        if (kind == 1) begin
          cur = bg ^ (16'($urandom) & 16'h18E3);
        end else if (kind == 2) begin
          case ($urandom_range(0, 4))
            0: bg = 16'h0000;
            1: bg = 16'hFFFF;
            2: bg = 16'hF800;
            3: bg = 16'h07E0;
            default: bg = 16'h001F;
          endcase
        end else if (kind == 3 && $urandom_range(0, 1) == 1) begin
          cur = ~bg;
        end
        send_pixel(bg, cur);
      end
      settle();
    end

    if (sb.mismatches == 0) begin
      $display("motion_pixel_diff_and_background_update_top_test: clean");
    end else begin
      $display("motion_pixel_diff_and_background_update_top_test: errors");
    end
    $finish;
  end
endmodule
